[src/ptcv_pkg.sv]
// Shared widths and register codes for the point to chunk / local voxel mapper.
package ptcv_pkg;

	localparam int PT_W         = 32;
	localparam int INV_W        = 24;
	localparam int INV_FRAC_BITS = 16;
	localparam int PROD_W       = PT_W + INV_W + 1;
	localparam int VOX_W        = 24;
	localparam int QUO_W        = VOX_W - 1;
	localparam int LOC_W        = 10;
	localparam int EDGE_CFG_W   = 11;
	localparam int CFG_W        = 24;
	localparam int LANES        = 3;

	typedef enum logic [0:0] {
		REG_INV_VOXEL_SIZE = 1'b0,
		REG_CHUNK_EDGE     = 1'b1
	} reg_idx_t;

endpackage

[src/ptcv_voxel.sv]
// One axis lane front end: scale by inverse voxel size, floor and saturate to 24 bits.
module ptcv_voxel #(
	parameter int POINT_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic [1:0]                        en,
	input  logic signed [ptcv_pkg::PT_W-1:0]  point,
	input  logic [ptcv_pkg::INV_W-1:0]        inv,
	output logic signed [ptcv_pkg::VOX_W-1:0] voxel
);

	localparam int SH = POINT_FRAC_BITS + ptcv_pkg::INV_FRAC_BITS;
	localparam int PW = ptcv_pkg::PROD_W;
	localparam int VW = ptcv_pkg::VOX_W;
	localparam int INV_W_S = ptcv_pkg::INV_W;

	logic signed [PW-1:0]    prod_s1;
	logic signed [VW-1:0]    vox_s2;
	logic signed [INV_W_S:0] inv_s;
	logic signed [PW-1:0]    flo;
	logic                    ovf_hi;
	logic                    ovf_lo;
	logic signed [VW-1:0]    sat;

	assign inv_s = {1'b0, inv};
	assign flo   = prod_s1 >>> SH;
	assign ovf_hi = !flo[PW-1] && (flo[PW-2:VW-1] != '0);
	assign ovf_lo = flo[PW-1] && (flo[PW-2:VW-1] != '1);

	always_comb begin
		if (ovf_hi) begin
			sat = {1'b0, {(VW-1){1'b1}}};
		end else if (ovf_lo) begin
			sat = {1'b1, {(VW-1){1'b0}}};
		end else begin
			sat = flo[VW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= point * inv_s;
		end
		if (en[1]) begin
			vox_s2 <= sat;
		end
	end

	assign voxel = vox_s2;

endmodule

[src/ptcv_div.sv]
// One axis lane back end: pipelined restoring divider, one quotient bit per stage.
module ptcv_div #(
	parameter int EW = 11
) (
	input  logic                         clk,
	input  logic [ptcv_pkg::QUO_W-1:0]   en,
	input  logic [ptcv_pkg::QUO_W-1:0]   num,
	input  logic [EW-1:0]                edge_len,
	input  logic [ptcv_pkg::VOX_W-1:0]   vox_in,
	output logic [ptcv_pkg::QUO_W-1:0]   quo,
	output logic [EW-1:0]                rem,
	output logic [ptcv_pkg::VOX_W-1:0]   vox_out
);

	localparam int NB = ptcv_pkg::QUO_W;
	localparam int VW = ptcv_pkg::VOX_W;

	logic [EW-1:0] rem_s [NB];
	logic [NB-1:0] quo_s [NB];
	logic [NB-1:0] num_s [NB];
	logic [VW-1:0] vox_s [NB];

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [EW-1:0] rem_in;
		logic [NB-1:0] quo_in;
		logic [NB-1:0] quo_nx;
		logic [NB-1:0] num_in;
		logic [VW-1:0] vox_i;
		logic [EW:0]   trial;
		logic [EW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
			assign vox_i  = vox_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign num_in = num_s[k-1];
			assign vox_i  = vox_s[k-1];
		end

		assign trial  = {rem_in, num_in[NB-1-k]};
		assign ge     = trial >= {1'b0, edge_len};
		assign diff   = trial - {1'b0, edge_len};
		assign quo_nx = quo_in | (NB'(ge) << (NB-1-k));

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? diff[EW-1:0] : trial[EW-1:0];
				quo_s[k] <= quo_nx;
				num_s[k] <= num_in;
				vox_s[k] <= vox_i;
			end
		end
	end

	assign quo     = quo_s[NB-1];
	assign rem     = rem_s[NB-1];
	assign vox_out = vox_s[NB-1];

endmodule

[src/point_to_chunk_local_voxel.sv]
// Top level of the point to chunk / local voxel mapper.
//
// Input channel: in_valid / in_stall carry one point (point_x, point_y, point_z,
// signed fixed point). Output channel: out_valid / out_stall carry the voxel,
// chunk and local coordinates of that point. A request moves when valid is high
// and stall is low.
// A point passes the scale multiply and saturation registers, a divider stage for
// each quotient bit of the chunk divider, and then the output register.
// Throughput is one point per cycle while not stalled; the three axes run in parallel lanes.
// A stalled result holds in the output register; earlier stages keep taking
// points until every stage is full, then in_stall rises.
// Configuration: cfg_we writes register cfg_index (0 inverse voxel size, 1 chunk
// edge) with cfg_wdata; write only while the pipeline is empty.
// Reset clears all valid flags and loads inverse size 20.0 and edge 16 (or MAX_CHUNK_EDGE if smaller).
module point_to_chunk_local_voxel #(
	parameter int POINT_FRAC_BITS = 16,
	parameter int MAX_CHUNK_EDGE  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [ptcv_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_x,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_y,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ptcv_pkg::VOX_W-1:0]   voxel_x,
	output logic signed [ptcv_pkg::VOX_W-1:0]   voxel_y,
	output logic signed [ptcv_pkg::VOX_W-1:0]   voxel_z,
	output logic signed [ptcv_pkg::VOX_W-1:0]   chunk_x,
	output logic signed [ptcv_pkg::VOX_W-1:0]   chunk_y,
	output logic signed [ptcv_pkg::VOX_W-1:0]   chunk_z,
	output logic [ptcv_pkg::LOC_W-1:0]          local_x,
	output logic [ptcv_pkg::LOC_W-1:0]          local_y,
	output logic [ptcv_pkg::LOC_W-1:0]          local_z
);

	localparam int EW = $clog2(MAX_CHUNK_EDGE + 1);
	localparam int NB = ptcv_pkg::QUO_W;
	localparam int S  = 2 + NB;
	localparam int VW = ptcv_pkg::VOX_W;
	localparam int LW = ptcv_pkg::LOC_W;
	localparam int NL = ptcv_pkg::LANES;
	localparam int EDGE_RST  = (16 > MAX_CHUNK_EDGE) ? MAX_CHUNK_EDGE : 16;
	localparam logic [ptcv_pkg::INV_W-1:0] INV_RST = ptcv_pkg::INV_W'(1310720);

	logic [ptcv_pkg::INV_W-1:0] inv_q;
	logic [EW-1:0]              edge_q;
	logic [31:0]                edge_wr;
	logic [ptcv_pkg::EDGE_CFG_W-1:0] edge_raw;

	logic [S-1:0] vld_q;
	logic [S:0]   rdy;

	logic signed [ptcv_pkg::PT_W-1:0] pt [NL];
	logic [VW-1:0] vox_o_q [NL];
	logic [VW-1:0] chk_o_q [NL];
	logic [LW-1:0] loc_o_q [NL];
	logic          out_valid_q;

	assign edge_raw = cfg_wdata[ptcv_pkg::EDGE_CFG_W-1:0];

	always_comb begin
		if (edge_raw == '0) begin
			edge_wr = 32'd1;
		end else if (32'(edge_raw) > 32'(MAX_CHUNK_EDGE)) begin
			edge_wr = 32'(MAX_CHUNK_EDGE);
		end else begin
			edge_wr = 32'(edge_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q  <= INV_RST;
			edge_q <= EW'(EDGE_RST);
		end else if (cfg_we) begin
			unique case (ptcv_pkg::reg_idx_t'(cfg_index))
				ptcv_pkg::REG_INV_VOXEL_SIZE: inv_q  <= cfg_wdata[ptcv_pkg::INV_W-1:0];
				ptcv_pkg::REG_CHUNK_EDGE:     edge_q <= edge_wr[EW-1:0];
				default: ;
			endcase
		end
	end

	assign rdy[S] = !out_valid_q || !out_stall;
	for (genvar k = 0; k < S; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end
	assign in_stall = !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < S; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (rdy[S]) begin
				out_valid_q <= vld_q[S-1];
			end
		end
	end

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	for (genvar a = 0; a < NL; a++) begin : g_lane
		logic signed [VW-1:0] vox;
		logic [NB-1:0]        num;
		logic [NB-1:0]        quo;
		logic [EW-1:0]        rem;
		logic [VW-1:0]        vox_d;
		logic                 neg;
		logic [VW-1:0]        quo_x;
		logic [EW-1:0]        loc;
		logic [EW+LW-1:0]     loc_x;

		ptcv_voxel #(
			.POINT_FRAC_BITS(POINT_FRAC_BITS)
		) u_voxel (
			.clk   (clk),
			.en    (rdy[1:0]),
			.point (pt[a]),
			.inv   (inv_q),
			.voxel (vox)
		);

		assign num = vox[NB-1:0] ^ {NB{vox[VW-1]}};

		ptcv_div #(
			.EW(EW)
		) u_div (
			.clk      (clk),
			.en       (rdy[S-1:2]),
			.num      (num),
			.edge_len (edge_q),
			.vox_in   (vox),
			.quo      (quo),
			.rem      (rem),
			.vox_out  (vox_d)
		);

		assign neg   = vox_d[VW-1];
		assign quo_x = {1'b0, quo};
		assign loc   = neg ? (edge_q - EW'(1) - rem) : rem;
		assign loc_x = {{LW{1'b0}}, loc};

		always_ff @(posedge clk) begin
			if (rdy[S]) begin
				vox_o_q[a] <= vox_d;
				chk_o_q[a] <= neg ? ~quo_x : quo_x;
				loc_o_q[a] <= loc_x[LW-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign voxel_x   = vox_o_q[0];
	assign voxel_y   = vox_o_q[1];
	assign voxel_z   = vox_o_q[2];
	assign chunk_x   = chk_o_q[0];
	assign chunk_y   = chk_o_q[1];
	assign chunk_z   = chk_o_q[2];
	assign local_x   = loc_o_q[0];
	assign local_y   = loc_o_q[1];
	assign local_z   = loc_o_q[2];

endmodule

[verif/voxel_coord_checker.sv]
// Watches the mapper's channels, predicts each point's coordinates and compares them.
module voxel_coord_checker #(
	parameter int POINT_FRAC_BITS = 16,
	parameter int MAX_CHUNK_EDGE  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [ptcv_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_x,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_y,
	input  logic signed [ptcv_pkg::PT_W-1:0]    point_z,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   voxel_x,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   voxel_y,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   voxel_z,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   chunk_x,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   chunk_y,
	input  logic signed [ptcv_pkg::VOX_W-1:0]   chunk_z,
	input  logic [ptcv_pkg::LOC_W-1:0]          local_x,
	input  logic [ptcv_pkg::LOC_W-1:0]          local_y,
	input  logic [ptcv_pkg::LOC_W-1:0]          local_z,
	output int                                  mismatches,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = ptcv_pkg::VOX_W;
	localparam logic [ptcv_pkg::INV_W-1:0]      INV_SCALE_RESET  = 24'd1310720;
	localparam logic [ptcv_pkg::EDGE_CFG_W-1:0] CHUNK_EDGE_RESET = 11'd16;
	localparam longint                          VOX_MAX          = 64'sd8388607;
	localparam longint                          VOX_MIN          = -64'sd8388608;

	typedef struct packed {
		logic [ptcv_pkg::VOX_W-1:0] voxel;
		logic [ptcv_pkg::VOX_W-1:0] chunk;
		logic [ptcv_pkg::LOC_W-1:0] offset;
	} axis_coord_t;

	typedef struct packed {
		axis_coord_t x;
		axis_coord_t y;
		axis_coord_t z;
	} point_coord_t;

	logic [ptcv_pkg::INV_W-1:0]      inv_scale = INV_SCALE_RESET;
	logic [ptcv_pkg::EDGE_CFG_W-1:0] edge_len  = CHUNK_EDGE_RESET;
	point_coord_t                    expected_coords[$];
	point_coord_t                    oldest_coord;
	point_coord_t                    newest_coord;
	int                              fail_count = 0;

	function automatic axis_coord_t map_axis(logic signed [ptcv_pkg::PT_W-1:0] pt,
			logic [ptcv_pkg::INV_W-1:0] scale, logic [ptcv_pkg::EDGE_CFG_W-1:0] edge_cfg);
		longint      prod;
		longint      vox;
		longint      span;
		longint      chk;
		longint      off;
		axis_coord_t res;
		prod = longint'(pt) * longint'(scale);
		vox  = prod >>> (POINT_FRAC_BITS + ptcv_pkg::INV_FRAC_BITS);
		if (vox > VOX_MAX) vox = VOX_MAX;
		if (vox < VOX_MIN) vox = VOX_MIN;
		span = longint'(edge_cfg);
		if (span < 1) span = 1;
		if (span > MAX_CHUNK_EDGE) span = MAX_CHUNK_EDGE;
		chk = (vox >= 0) ? vox / span : (vox - span + 1) / span;
		off = vox - chk * span;
		res.voxel  = vox[ptcv_pkg::VOX_W-1:0];
		res.chunk  = chk[ptcv_pkg::VOX_W-1:0];
		res.offset = off[ptcv_pkg::LOC_W-1:0];
		return res;
	endfunction

	function void check_field(string name, logic [ptcv_pkg::VOX_W-1:0] want,
			logic [ptcv_pkg::VOX_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s mismatch, expected 0x%h, got 0x%h", $realtime, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			inv_scale = INV_SCALE_RESET;
			edge_len  = CHUNK_EDGE_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptcv_pkg::REG_INV_VOXEL_SIZE:
						inv_scale = cfg_wdata[ptcv_pkg::INV_W-1:0];
					ptcv_pkg::REG_CHUNK_EDGE:
						edge_len  = cfg_wdata[ptcv_pkg::EDGE_CFG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				newest_coord = '{
					x: map_axis(point_x, inv_scale, edge_len),
					y: map_axis(point_y, inv_scale, edge_len),
					z: map_axis(point_z, inv_scale, edge_len)};
				expected_coords.insert(expected_coords.size(), newest_coord);
			end
			if (out_valid && !out_stall) begin
				if (expected_coords.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with no point outstanding, voxel 0x%h 0x%h 0x%h",
							$realtime, voxel_x, voxel_y, voxel_z);
				end else begin
					oldest_coord = expected_coords.pop_front();
					check_field("voxel_x", oldest_coord.x.voxel, voxel_x);
					check_field("voxel_y", oldest_coord.y.voxel, voxel_y);
					check_field("voxel_z", oldest_coord.z.voxel, voxel_z);
					check_field("chunk_x", oldest_coord.x.chunk, chunk_x);
					check_field("chunk_y", oldest_coord.y.chunk, chunk_y);
					check_field("chunk_z", oldest_coord.z.chunk, chunk_z);
					check_field("local_x", VW'(oldest_coord.x.offset), VW'(local_x));
					check_field("local_y", VW'(oldest_coord.y.offset), VW'(local_y));
					check_field("local_z", VW'(oldest_coord.z.offset), VW'(local_z));
				end
			end
		end
		pending    <= expected_coords.size();
		mismatches <= fail_count;
	end

endmodule

[verif/point_to_chunk_local_voxel_tb.sv]
// Top of the mapper regression: clock, reset, register settings, point stimulus and verdict.
module point_to_chunk_local_voxel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POINT_FRAC_BITS = 16;
	localparam int MAX_CHUNK_EDGE  = 1024;
	localparam int PHASES          = 12;
	localparam int POINTS_PER_PHASE = 78;
	localparam int DRAIN_CYCLES    = 30;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               cfg_we    = 1'b0;
	ptcv_pkg::reg_idx_t                 cfg_index = ptcv_pkg::REG_INV_VOXEL_SIZE;
	logic [ptcv_pkg::CFG_W-1:0]         cfg_wdata = '0;
	logic                               in_valid  = 1'b0;
	logic                               in_stall;
	logic signed [ptcv_pkg::PT_W-1:0]   point_x   = '0;
	logic signed [ptcv_pkg::PT_W-1:0]   point_y   = '0;
	logic signed [ptcv_pkg::PT_W-1:0]   point_z   = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [ptcv_pkg::VOX_W-1:0]  voxel_x, voxel_y, voxel_z;
	logic signed [ptcv_pkg::VOX_W-1:0]  chunk_x, chunk_y, chunk_z;
	logic [ptcv_pkg::LOC_W-1:0]         local_x, local_y, local_z;
	int                                 mismatches;
	int                                 pending;
	int                                 tx_idle_pct = 0;
	int                                 rx_stall_pct = 0;

	logic [ptcv_pkg::PT_W-1:0] corner_coords[16] = '{
		32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF,
		32'h80000000, 32'h00010000, 32'hFFFF0000, 32'h0000CCCD,
		32'h0000CCCC, 32'hFFFF3333, 32'hFFFF3334, 32'h00000CCD,
		32'hFFFFF333, 32'h55555555, 32'hAAAAAAAA, 32'h00008000
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	point_to_chunk_local_voxel #(
		.POINT_FRAC_BITS(POINT_FRAC_BITS),
		.MAX_CHUNK_EDGE (MAX_CHUNK_EDGE)
	) dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.in_valid, .in_stall, .point_x, .point_y, .point_z,
		.out_valid, .out_stall,
		.voxel_x, .voxel_y, .voxel_z,
		.chunk_x, .chunk_y, .chunk_z,
		.local_x, .local_y, .local_z
	);

	voxel_coord_checker #(
		.POINT_FRAC_BITS(POINT_FRAC_BITS),
		.MAX_CHUNK_EDGE (MAX_CHUNK_EDGE)
	) coord_check (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.in_valid, .in_stall, .point_x, .point_y, .point_z,
		.out_valid, .out_stall,
		.voxel_x, .voxel_y, .voxel_z,
		.chunk_x, .chunk_y, .chunk_z,
		.local_x, .local_y, .local_z,
		.mismatches, .pending
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	task automatic send_point(input logic [ptcv_pkg::PT_W-1:0] px,
			input logic [ptcv_pkg::PT_W-1:0] py, input logic [ptcv_pkg::PT_W-1:0] pz);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= px;
		point_y  <= py;
		point_z  <= pz;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic set_scale_and_edge(input logic [ptcv_pkg::CFG_W-1:0] scale,
			input logic [ptcv_pkg::CFG_W-1:0] edge_word);
		cfg_we    <= 1'b1;
		cfg_index <= ptcv_pkg::REG_INV_VOXEL_SIZE;
		cfg_wdata <= scale;
		@(posedge clk);
		cfg_index <= ptcv_pkg::REG_CHUNK_EDGE;
		cfg_wdata <= edge_word;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [ptcv_pkg::PT_W-1:0] draw_coord();
		logic [ptcv_pkg::PT_W-1:0] v;
		int unsigned               k;
		case ($urandom_range(2))
			0: v = $urandom;
			1: begin
				k = $urandom_range(31, 1);
				v = $urandom >> (32 - k);
				if ($urandom_range(1)) v = -v;
			end
			default: begin
				v = ptcv_pkg::PT_W'($urandom_range(300)) << POINT_FRAC_BITS;
				v = v + ptcv_pkg::PT_W'($urandom_range(2)) - 1;
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [ptcv_pkg::CFG_W-1:0] scale;
		logic [ptcv_pkg::CFG_W-1:0] edge_word;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				edge_word = '0;
				case (phase)
					1:  begin scale = 24'hFFFFFF; edge_word[10:0] = 11'd1; end
					2:  begin scale = 24'h000000; edge_word[10:0] = 11'd16; end
					3:  begin scale = 24'h000001; edge_word[10:0] = 11'd2; end
					4:  begin scale = 24'd1310720; edge_word[10:0] = 11'd0; end
					5:  begin scale = 24'h010000; edge_word[10:0] = 11'd1024; end
					6:  begin scale = 24'hFFFFFF; edge_word[10:0] = 11'd1025; end
					7:  begin scale = 24'h800000; edge_word = {13'($urandom), 11'h7FF}; end
					8:  begin scale = 24'($urandom_range(24'hFFFFFF, 1)); edge_word[10:0] = 11'd7; end
					9:  begin scale = 24'($urandom_range(24'h0FFFFF, 1)); edge_word[10:0] = 11'd1000; end
					10: begin scale = 24'd1310720; edge_word[10:0] = 11'd16; end
					default: begin scale = 24'($urandom); edge_word = 24'($urandom); end
				endcase
				set_scale_and_edge(scale, edge_word);
			end
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
				default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
			endcase
			if (phase == 0) begin
				for (int i = 0; i < 16; i++)
					send_point(corner_coords[i], corner_coords[(i + 3) % 16],
						corner_coords[(i + 7) % 16]);
			end
			for (int i = 0; i < POINTS_PER_PHASE; i++)
				send_point(draw_coord(), draw_coord(), draw_coord());
			in_valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("point_to_chunk_local_voxel regression: pass");
		end else begin
			$display("point_to_chunk_local_voxel regression: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("point_to_chunk_local_voxel regression: fail");
		$finish;
	end

endmodule

[files.f]
src/ptcv_pkg.sv
src/ptcv_voxel.sv
src/ptcv_div.sv
src/point_to_chunk_local_voxel.sv
verif/voxel_coord_checker.sv
verif/point_to_chunk_local_voxel_tb.sv
